// ===== rtl/rtpr_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP packetizer package
// Shared sizes, codes and control structs for the RTP header generator with
// its retransmit ring.
// ----------------------------------------------------------------------------
package rtpr_pkg;

  // Ring geometry. The ring holds the most recent RING_DEPTH sent headers.
  localparam int unsigned RING_DEPTH = 512;
  localparam int unsigned SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FILL_W     = $clog2(RING_DEPTH + 1);

  // Field widths of the stream items.
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned SSRC_W     = 32;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned SAMP_W     = 16;
  localparam int unsigned KIND_W     = 7;
  localparam int unsigned SLOT_OUT_W = 9;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // Stored ring entry: length, source, timestamp, header word (low bits).
  localparam int unsigned RAM_W      = LEN_W + SSRC_W + TS_W + 32;

  // First header byte: version 2, no padding, no extension, no CSRC.
  localparam logic [7:0] RTP_V2_BYTE = 8'h80;

  // Reset value of the sync interval register.
  localparam logic [CNT_W-1:0] SYNC_INTERVAL_RST = 32'd44100;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_FETCH = 2'd1,
    MODE_SYNC  = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SSRC            = 2'd0,
    CFG_START_SEQUENCE  = 2'd1,
    CFG_START_TIMESTAMP = 2'd2,
    CFG_SYNC_INTERVAL   = 2'd3
  } cfg_idx_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the incoming word
    logic rd_issue;  // look up the ring and start the read
    logic commit;    // update state and load the result register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_fetch;
  } status_t;

  // One result word.
  typedef struct packed {
    logic                  sync_due;
    logic                  found;
    logic [LEN_W-1:0]      stored_length;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SSRC_W-1:0]     source_id;
    logic [TS_W-1:0]       timestamp;
    logic [31:0]           header_word;
  } result_t;

endpackage

// ===== rtl/rtpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data that holds while
// no read is issued.
// ----------------------------------------------------------------------------
module rtpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rtpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// RTP packetizer controller
// Sequences one request at a time through capture, ring access and result
// hand-off, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module rtpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  rtpr_pkg::status_t status_i,
  output rtpr_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a word when empty or when it drains now.
  assign out_free = !out_valid_q || m_ready_i;

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_fetch) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_READ;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

  // A new result never overwrites a word that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && !m_ready_i))
    else $error("result overwritten while stalled");

  // A ring read is always followed by the read state, which does its commit.
  a_read_then_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> (state_q == S_READ))
    else $error("ring read not followed by read stage");

endmodule

// ===== rtl/rtpr_datapath.sv =====
// ----------------------------------------------------------------------------
// RTP packetizer datapath
// Holds the configuration, the running sequence, timestamp and sample
// counters, the retransmit ring and the result register.
// ----------------------------------------------------------------------------
module rtpr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rtpr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rtpr_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic [1:0]                          mode_i,
  input  logic [rtpr_pkg::SAMP_W-1:0]         sample_count_i,
  input  logic [rtpr_pkg::LEN_W-1:0]          payload_length_i,
  input  logic [rtpr_pkg::KIND_W-1:0]         payload_kind_i,
  input  logic                                marker_i,
  input  logic [rtpr_pkg::SEQ_W-1:0]          requested_sequence_i,
  input  rtpr_pkg::cmd_t                      cmd_i,
  output rtpr_pkg::status_t                   status_o,
  output rtpr_pkg::result_t                   res_o
);

  // Captured request.
  rtpr_pkg::mode_e                  mode_q;
  logic [rtpr_pkg::SAMP_W-1:0]      samples_q;
  logic [rtpr_pkg::LEN_W-1:0]       plen_q;
  logic [rtpr_pkg::KIND_W-1:0]      kind_q;
  logic                             marker_q;
  logic [rtpr_pkg::SEQ_W-1:0]       req_q;

  // Configuration and running state.
  logic [rtpr_pkg::SSRC_W-1:0]      ssrc_q, ssrc_d;
  logic [rtpr_pkg::CNT_W-1:0]       interval_q, interval_d;
  logic [rtpr_pkg::SEQ_W-1:0]       next_seq_q, next_seq_d;
  logic [rtpr_pkg::TS_W-1:0]        position_q, position_d;
  logic [rtpr_pkg::SLOT_W-1:0]      write_slot_q, write_slot_d;
  logic [rtpr_pkg::FILL_W-1:0]      fill_q, fill_d;
  logic [rtpr_pkg::CNT_W-1:0]       counter_q, counter_d;

  // Fetch lookup results.
  logic                             hit_q;
  logic [rtpr_pkg::SLOT_W-1:0]      fslot_q;
  logic [rtpr_pkg::SEQ_W-1:0]       back;
  logic                             hit;
  logic [rtpr_pkg::FILL_W-1:0]      delta;
  logic [rtpr_pkg::SLOT_W:0]        fsum;
  logic [rtpr_pkg::SLOT_W-1:0]      fslot;

  // Send helpers.
  logic [31:0]                      header;
  logic [rtpr_pkg::CNT_W:0]         count_sum;
  logic                             sync_due;

  // Ring memory port.
  logic                             ram_we;
  logic [rtpr_pkg::RAM_W-1:0]       ram_wdata;
  logic [rtpr_pkg::RAM_W-1:0]       ram_rdata;

  rtpr_pkg::result_t                res_q, res_d;

  assign status_o.is_fetch = (mode_q == rtpr_pkg::MODE_FETCH);

  // Capture the accepted word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= rtpr_pkg::mode_e'(mode_i);
      samples_q <= sample_count_i;
      plen_q    <= payload_length_i;
      kind_q    <= payload_kind_i;
      marker_q  <= marker_i;
      req_q     <= requested_sequence_i;
    end
  end

  // Wrap-aware window check: distance back from the newest sent sequence.
  always_comb begin
    back  = next_seq_q - rtpr_pkg::SEQ_W'(1) - req_q;
    hit   = (fill_q != '0) && (back < rtpr_pkg::SEQ_W'(fill_q));
    delta = rtpr_pkg::FILL_W'(back) + rtpr_pkg::FILL_W'(1);
    fsum  = {1'b0, write_slot_q} + (rtpr_pkg::SLOT_W + 1)'(rtpr_pkg::RING_DEPTH)
            - (rtpr_pkg::SLOT_W + 1)'(delta);
    if (fsum >= (rtpr_pkg::SLOT_W + 1)'(rtpr_pkg::RING_DEPTH)) begin
      fsum = fsum - (rtpr_pkg::SLOT_W + 1)'(rtpr_pkg::RING_DEPTH);
    end
    fslot = fsum[rtpr_pkg::SLOT_W-1:0];
  end

  // Register the lookup alongside the ring read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      hit_q   <= hit;
      fslot_q <= fslot;
    end
  end

  // Header word and saturating sample sum.
  assign header    = {rtpr_pkg::RTP_V2_BYTE, marker_q, kind_q, next_seq_q};
  assign count_sum = {1'b0, counter_q} + (rtpr_pkg::CNT_W + 1)'(samples_q);
  assign sync_due  = (interval_q != '0) && (counter_q > interval_q);

  assign ram_we    = cmd_i.commit && (mode_q == rtpr_pkg::MODE_SEND);
  assign ram_wdata = {plen_q, ssrc_q, position_q, header};

  rtpr_ram #(
    .Width (rtpr_pkg::RAM_W),
    .Depth (rtpr_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (write_slot_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (fslot),
    .rdata_o (ram_rdata)
  );

  // State update on commit and on configuration writes.
  always_comb begin
    ssrc_d       = ssrc_q;
    interval_d   = interval_q;
    next_seq_d   = next_seq_q;
    position_d   = position_q;
    write_slot_d = write_slot_q;
    fill_d       = fill_q;
    counter_d    = counter_q;
    res_d        = res_q;

    if (cmd_i.commit) begin
      res_d = '0;
      unique case (mode_q)
        rtpr_pkg::MODE_SEND: begin
          res_d.header_word   = header;
          res_d.timestamp     = position_q;
          res_d.source_id     = ssrc_q;
          res_d.slot          = rtpr_pkg::SLOT_OUT_W'(write_slot_q);
          res_d.stored_length = plen_q;
          if (fill_q < rtpr_pkg::FILL_W'(rtpr_pkg::RING_DEPTH)) begin
            fill_d = fill_q + rtpr_pkg::FILL_W'(1);
          end
          if (write_slot_q == rtpr_pkg::SLOT_W'(rtpr_pkg::RING_DEPTH - 1)) begin
            write_slot_d = '0;
          end else begin
            write_slot_d = write_slot_q + rtpr_pkg::SLOT_W'(1);
          end
          next_seq_d = next_seq_q + rtpr_pkg::SEQ_W'(1);
          position_d = position_q + rtpr_pkg::TS_W'(samples_q);
          if (count_sum[rtpr_pkg::CNT_W]) begin
            counter_d = '1;
          end else begin
            counter_d = count_sum[rtpr_pkg::CNT_W-1:0];
          end
        end
        rtpr_pkg::MODE_FETCH: begin
          if (hit_q) begin
            res_d.header_word   = ram_rdata[31:0];
            res_d.timestamp     = ram_rdata[63:32];
            res_d.source_id     = ram_rdata[95:64];
            res_d.stored_length = ram_rdata[111:96];
            res_d.slot          = rtpr_pkg::SLOT_OUT_W'(fslot_q);
            res_d.found         = 1'b1;
          end
        end
        rtpr_pkg::MODE_SYNC: begin
          if (sync_due) begin
            counter_d      = '0;
            res_d.sync_due = 1'b1;
          end
        end
        rtpr_pkg::MODE_FLUSH: begin
          fill_d    = '0;
          counter_d = '0;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end

    if (cfg_we_i) begin
      unique case (rtpr_pkg::cfg_idx_e'(cfg_index_i))
        rtpr_pkg::CFG_SSRC:            ssrc_d     = cfg_data_i;
        rtpr_pkg::CFG_START_SEQUENCE:  next_seq_d = cfg_data_i[rtpr_pkg::SEQ_W-1:0];
        rtpr_pkg::CFG_START_TIMESTAMP: position_d = cfg_data_i;
        rtpr_pkg::CFG_SYNC_INTERVAL:   interval_d = cfg_data_i;
        default: begin
          ssrc_d = ssrc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssrc_q       <= '0;
      interval_q   <= rtpr_pkg::SYNC_INTERVAL_RST;
      next_seq_q   <= '0;
      position_q   <= '0;
      write_slot_q <= '0;
      fill_q       <= '0;
      counter_q    <= '0;
    end else begin
      ssrc_q       <= ssrc_d;
      interval_q   <= interval_d;
      next_seq_q   <= next_seq_d;
      position_q   <= position_d;
      write_slot_q <= write_slot_d;
      fill_q       <= fill_d;
      counter_q    <= counter_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

  // The fill count never passes the ring depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= rtpr_pkg::FILL_W'(rtpr_pkg::RING_DEPTH))
    else $error("fill count beyond ring depth");

  // The write slot stays inside the ring.
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_slot_q <= rtpr_pkg::SLOT_W'(rtpr_pkg::RING_DEPTH - 1))
    else $error("write slot outside ring");

  // A reported sync leaves the sample counter cleared.
  a_sync_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (mode_q == rtpr_pkg::MODE_SYNC) && sync_due && !cfg_we_i)
    |=> (counter_q == '0))
    else $error("sample counter not cleared after sync report");

endmodule

// ===== rtl/rtp_packetizer_retransmit_ring_core.sv =====
// ----------------------------------------------------------------------------
// RTP packetizer with retransmit ring
// Builds RTP headers for sent packets, keeps them in a ring for retransmit
// lookups, and reports when a sync report is due.
// ----------------------------------------------------------------------------
// Send, sync and flush requests are captured on acceptance and then committed
// to the result register; a fetch adds the registered ring read in between.
// Commit waits while a stalled result is held, and the controller takes no new
// request until the last one is committed.
// Reset (async, active low) clears counters and control; the ring contents
// stay undefined and are guarded by the fill count, so no clearing pass runs.
module rtp_packetizer_retransmit_ring_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [rtpr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rtpr_pkg::CFG_W-1:0]         cfg_data_i,
  // Request stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_count[15:0], payload_length[31:16], payload_kind[38:32],
  // marker[39], requested_sequence[55:40]
  input  logic [55:0]                        s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                         s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // header_word[31:0], timestamp[63:32], source_id[95:64], slot[104:96],
  // stored_length[120:105], zero fill[127:121]
  output logic [127:0]                       m_axis_tdata,
  // found[0], sync_due[1]
  output logic [1:0]                         m_axis_tuser
);

  rtpr_pkg::cmd_t    cmd;
  rtpr_pkg::status_t status;
  rtpr_pkg::result_t res;

  rtpr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rtpr_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .mode_i               (s_axis_tuser),
    .sample_count_i       (s_axis_tdata[15:0]),
    .payload_length_i     (s_axis_tdata[31:16]),
    .payload_kind_i       (s_axis_tdata[38:32]),
    .marker_i             (s_axis_tdata[39]),
    .requested_sequence_i (s_axis_tdata[55:40]),
    .cmd_i                (cmd),
    .status_o             (status),
    .res_o                (res)
  );

  // Pack the result word onto the output stream.
  assign m_axis_tdata = {7'd0, res.stored_length, res.slot, res.source_id,
                         res.timestamp, res.header_word};
  assign m_axis_tuser = {res.sync_due, res.found};

endmodule
